// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker in wsa_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Assert a condition that must hold even while reset is active
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- hdl/wsa_pkg.sv -----
`default_nettype none
package wsa_pkg;

  localparam int unsigned MaxAps = 16;
  localparam int unsigned IdxW = $clog2(MaxAps);
  localparam int unsigned CntW = $clog2(MaxAps + 1);

  localparam logic [23:0] ReqTimeoutRst = 24'd1000000;
  localparam logic [23:0] ForgetAgeRst = 24'd5000000;
  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_BEACON   = 3'd0,
    CMD_ACK      = 3'd1,
    CMD_NACK     = 3'd2,
    CMD_DISASSOC = 3'd3,
    CMD_CLEANUP  = 3'd4,
    CMD_DATA     = 3'd5,
    CMD_TIMER    = 3'd6,
    CMD_IGNORE   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    TX_NONE     = 2'd0,
    TX_ASSOC    = 2'd1,
    TX_DISASSOC = 2'd2,
    TX_DATA     = 2'd3
  } tx_kind_e;

  localparam logic CfgReqTimeout = 1'b0;
  localparam logic CfgForgetAge = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SELECT,
    ST_CLEAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] source_addr;
    logic signed [15:0] rx_strength;
    logic [47:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  tx_kind;
    logic [31:0] tx_dest;
    logic        is_associated;
    logic [31:0] partner_addr;
    logic        is_asking;
    logic [31:0] asked_addr;
    logic [47:0] time_added;
    logic        table_full_drop;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input item, reset scan
    logic find_step; // compare one entry against the source address
    logic find_done; // apply the beacon insert or refresh
    logic sel_step;  // test one entry for the best candidate
    logic sel_done;  // issue the association request if any
    logic clean_step; // test one entry for aging
    logic finish;    // apply simple commands, form the result
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_e cmd;
    logic scan_end;    // index at the current count
    logic found;       // beacon source already in the table
    logic need_select; // neither associated nor asking
  } stat_t;

endpackage
`default_nettype wire

// ----- hdl/wsa_if.sv -----
`default_nettype none
interface wsa_in_if;
  import wsa_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wsa_out_if;
  import wsa_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/wlan_station_ap_association.sv -----
`default_nettype none
// Station association engine. Each item takes one result; a beacon scans the
// table of up to 16 access points once to find its sender and, when the
// station is neither associated nor asking, once more to choose a candidate,
// one entry per cycle; cleanup walks the table once. One item is in the block
// at a time. Write configuration only while idle.
module wlan_station_ap_association (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  wsa_in_if.sink           in_if,
  wsa_out_if.source        out_if,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [23:0] cfg_data_i
);
  import wsa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  wsa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  wsa_dp u_dp (
    .clk_i, .rst_ni,
    .in_i      (in_if.data),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .out_o     (out_if.data)
  );

endmodule
`default_nettype wire

// ----- hdl/wsa_ctrl.sv -----
`default_nettype none
module wsa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire wsa_pkg::stat_t stat_i,
  output wsa_pkg::ctrl_t      ctrl_o
);
  import wsa_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FIND;
      end
      ST_FIND: begin
        case (stat_i.cmd)
          CMD_BEACON: begin
            if (stat_i.found || stat_i.scan_end) state_d = ST_SELECT;
          end
          CMD_CLEANUP: state_d = ST_CLEAN;
          default: state_d = ST_OUT;
        endcase
      end
      ST_SELECT: begin
        if (!stat_i.need_select || stat_i.scan_end) state_d = ST_OUT;
      end
      ST_CLEAN: begin
        if (stat_i.scan_end) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_FIND: begin
        if (stat_i.cmd == CMD_BEACON) begin
          ctrl_o.find_step = 1'b1;
          ctrl_o.find_done = stat_i.found || stat_i.scan_end;
        end else if (stat_i.cmd != CMD_CLEANUP) begin
          ctrl_o.finish = 1'b1;
        end
      end
      ST_SELECT: begin
        ctrl_o.sel_step = stat_i.need_select && !stat_i.scan_end;
        ctrl_o.sel_done = stat_i.need_select && stat_i.scan_end;
      end
      ST_CLEAN: ctrl_o.clean_step = !stat_i.scan_end;
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

// ----- hdl/wsa_dp.sv -----
`default_nettype none
module wsa_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wsa_pkg::in_item_t in_i,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [23:0]       cfg_data_i,
  input  wire wsa_pkg::ctrl_t    ctrl_i,
  output wsa_pkg::stat_t         stat_o,
  output wsa_pkg::out_item_t     out_o
);
  import wsa_pkg::*;

  // Access point table, registers read at the scan index, the best candidate and the last entry
  logic [31:0]        ap_addr_q  [MaxAps];
  logic signed [15:0] ap_str_q   [MaxAps];
  logic [47:0]        ap_heard_q [MaxAps];
  logic [47:0]        ap_asked_q [MaxAps];

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] idx_q;
  in_item_t        item_q;
  logic [23:0]     req_to_q, forget_q;
  logic [31:0]     partner_q, asking_q;
  logic            partner_v_q, asking_v_q, armed_q;
  logic [47:0]     joined_q, deadline_q;
  logic            have_q;
  logic [IdxW-1:0] best_q;
  logic signed [15:0] best_s_q;
  logic [1:0]      kind_q;
  logic [31:0]     dest_q;
  logic [47:0]     added_q;
  logic            drop_q;

  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] last;
  logic [48:0]     asked_sum, heard_sum, dl_sum;
  logic            eligible, aged, match;
  logic [47:0]     dur;

  assign idx = idx_q[IdxW-1:0];
  assign last = IdxW'(count_q - CntW'(1));
  assign match = ap_addr_q[idx] == item_q.source_addr;
  assign asked_sum = {1'b0, ap_asked_q[idx]} + {25'd0, req_to_q};
  assign eligible = asked_sum < {1'b0, item_q.now_time};
  assign heard_sum = {1'b0, ap_heard_q[idx]} + {25'd0, forget_q};
  assign aged = heard_sum < {1'b0, item_q.now_time};
  assign dl_sum = {1'b0, item_q.now_time} + {25'd0, req_to_q};
  assign dur = (item_q.now_time >= joined_q) ? item_q.now_time - joined_q : '0;

  assign stat_o.cmd = cmd_e'(item_q.command);
  assign stat_o.scan_end = idx_q >= count_q;
  assign stat_o.found = !stat_o.scan_end && match;
  assign stat_o.need_select = !partner_v_q && !asking_v_q;

  assign out_o.tx_kind = kind_q;
  assign out_o.tx_dest = dest_q;
  assign out_o.is_associated = partner_v_q;
  assign out_o.partner_addr = partner_v_q ? partner_q : '0;
  assign out_o.is_asking = asking_v_q;
  assign out_o.asked_addr = asking_v_q ? asking_q : '0;
  assign out_o.time_added = added_q;
  assign out_o.table_full_drop = drop_q;

  // Table entries
  always_ff @(posedge clk_i) begin
    if (ctrl_i.find_done) begin
      if (stat_o.found) begin
        ap_str_q[idx] <= item_q.rx_strength;
        ap_heard_q[idx] <= item_q.now_time;
      end else if (count_q < CntW'(MaxAps)) begin
        ap_addr_q[IdxW'(count_q)] <= item_q.source_addr;
        ap_asked_q[IdxW'(count_q)] <= '0;
        ap_str_q[IdxW'(count_q)] <= item_q.rx_strength;
        ap_heard_q[IdxW'(count_q)] <= item_q.now_time;
      end
    end
    if (ctrl_i.sel_done && have_q) ap_asked_q[best_q] <= item_q.now_time;
    if (ctrl_i.clean_step && aged) begin
      ap_addr_q[idx] <= ap_addr_q[last];
      ap_str_q[idx] <= ap_str_q[last];
      ap_heard_q[idx] <= ap_heard_q[last];
      ap_asked_q[idx] <= ap_asked_q[last];
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q <= in_i;
      kind_q <= TX_NONE;
      dest_q <= '0;
      added_q <= '0;
      drop_q <= 1'b0;
      have_q <= 1'b0;
      best_q <= '0;
      best_s_q <= '0;
    end
    if (ctrl_i.find_done && !stat_o.found && count_q >= CntW'(MaxAps)) drop_q <= 1'b1;
    if (ctrl_i.sel_step && eligible && (!have_q || ap_str_q[idx] > best_s_q)) begin
      have_q <= 1'b1;
      best_q <= idx;
      best_s_q <= ap_str_q[idx];
    end
    if (ctrl_i.sel_done && have_q) begin
      kind_q <= TX_ASSOC;
      dest_q <= ap_addr_q[best_q];
    end
    if (ctrl_i.clean_step && aged && partner_v_q && ap_addr_q[idx] == partner_q) begin
      kind_q <= TX_DISASSOC;
      dest_q <= partner_q;
      added_q <= dur;
    end
    if (ctrl_i.finish) begin
      case (cmd_e'(item_q.command))
        CMD_DISASSOC: if (partner_v_q && partner_q == item_q.source_addr) added_q <= dur;
        CMD_DATA: if (partner_v_q) begin
          kind_q <= TX_DATA;
          dest_q <= partner_q;
        end
        default: ;
      endcase
    end
  end

  // Control state: count, scan index, configuration, association
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q <= '0;
      req_to_q <= ReqTimeoutRst;
      forget_q <= ForgetAgeRst;
      partner_q <= '0;
      partner_v_q <= 1'b0;
      asking_q <= '0;
      asking_v_q <= 1'b0;
      joined_q <= '0;
      armed_q <= 1'b0;
      deadline_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgReqTimeout) req_to_q <= cfg_data_i;
        else forget_q <= cfg_data_i;
      end
      if (ctrl_i.load) idx_q <= '0;
      if (ctrl_i.find_step) idx_q <= idx_q + CntW'(1);
      if (ctrl_i.find_done) begin
        idx_q <= '0;
        if (!stat_o.found && count_q < CntW'(MaxAps)) count_q <= count_q + CntW'(1);
      end
      if (ctrl_i.sel_step) idx_q <= idx_q + CntW'(1);
      if (ctrl_i.sel_done && have_q) begin
        asking_q <= ap_addr_q[best_q];
        asking_v_q <= 1'b1;
        armed_q <= 1'b1;
        deadline_q <= dl_sum[48] ? TimeMax : dl_sum[47:0];
      end
      if (ctrl_i.clean_step) begin
        if (aged) begin
          count_q <= count_q - CntW'(1);
          if (partner_v_q && ap_addr_q[idx] == partner_q) begin
            partner_v_q <= 1'b0;
            partner_q <= '0;
          end
        end else begin
          idx_q <= idx_q + CntW'(1);
        end
      end
      if (ctrl_i.finish) begin
        case (cmd_e'(item_q.command))
          CMD_ACK: if (asking_v_q && asking_q == item_q.source_addr) begin
            partner_q <= item_q.source_addr;
            partner_v_q <= 1'b1;
            joined_q <= item_q.now_time;
            asking_v_q <= 1'b0;
            asking_q <= '0;
            armed_q <= 1'b0;
          end
          CMD_NACK: if (asking_v_q && asking_q == item_q.source_addr) begin
            partner_v_q <= 1'b0;
            partner_q <= '0;
            asking_v_q <= 1'b0;
            asking_q <= '0;
            armed_q <= 1'b0;
          end
          CMD_DISASSOC: if (partner_v_q && partner_q == item_q.source_addr) begin
            partner_v_q <= 1'b0;
            partner_q <= '0;
          end
          CMD_TIMER: if (armed_q && item_q.now_time >= deadline_q) begin
            partner_v_q <= 1'b0;
            partner_q <= '0;
            asking_v_q <= 1'b0;
            asking_q <= '0;
            armed_q <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/wsa_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module wsa_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic is_assoc,
  input wire logic is_asking,
  input wire logic [1:0] tx_kind
);
  import wsa_pkg::*;

  `ASSERT_IMPL(a_one_at_a_time, clk_i, rst_ni, out_valid |-> !in_ready)
  `ASSERT_IMPL(a_not_both, clk_i, rst_ni, out_valid |-> !(is_assoc && is_asking))
  `ASSERT_IMPL(a_out_holds, clk_i, rst_ni, (out_valid && !out_ready) |=> out_valid)
  `ASSERT_IMPL(a_req_sets_ask, clk_i, rst_ni, (out_valid && tx_kind == TX_ASSOC) |-> is_asking)
  `ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !out_valid)
endmodule

bind wlan_station_ap_association wsa_checker u_chk (
  .clk_i, .rst_ni,
  .in_ready (in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .is_assoc (out_if.data.is_associated),
  .is_asking(out_if.data.is_asking),
  .tx_kind  (out_if.data.tx_kind)
);
`default_nettype wire
